// ===== sv/lrg_pkg.sv =====
// shared constants, types and a saturation helper for the gradient descent trainer
// used by lrg_cell and logistic_regression_gd_trainer_unit
package lrg_pkg;

  localparam int MAX_FEATURES = 32;
  localparam int FEATURE_BITS = 16;
  localparam int IDX_W        = $clog2(MAX_FEATURES);
  localparam int CNT_W        = IDX_W + 1;
  localparam int SUM_W        = 40;
  localparam int ERR_W        = 18;
  localparam int W_W          = 32;

  // error broadcast handed from cell to cell
  typedef struct packed {
    logic                    vld;
    logic signed [ERR_W-1:0] err;
    logic [IDX_W-1:0]        lim;
  } chain_t;

  // writes from the controller into the row of cells
  typedef struct packed {
    logic                           row_we;
    logic [IDX_W-1:0]               row_idx;
    logic signed [FEATURE_BITS-1:0] row_val;
    logic                           w_we;
    logic [IDX_W-1:0]               w_idx;
    logic signed [W_W-1:0]          w_val;
  } cmd_t;

  function automatic logic signed [SUM_W-1:0] sat40(input logic signed [47:0] v);
    logic signed [47:0] hi;
    logic signed [47:0] lo;
    hi = 48'sd549755813887;
    lo = -48'sd549755813888;
    if (v > hi) return hi[SUM_W-1:0];
    else if (v < lo) return lo[SUM_W-1:0];
    else return v[SUM_W-1:0];
  endfunction

endpackage

// ===== sv/logistic_regression_gd_trainer_unit.sv =====
// top level of the logistic regression trainer: controller, shared update path
// and the row of lrg_cell instances; depends on lrg_pkg and lrg_cell
//
// input stream: one feature value per transfer, tdata = feature_value,
// tuser = row label, tlast = end of epoch. each value goes through accept,
// weight times feature and accumulate, using the single multiplier.
// a row end adds a sigmoid step, then the error ripples down the row of
// MAX_FEATURES (32) cells, one cell per cycle.
// on an epoch end each weight passes S_UPD1 and S_UPD2 in the shared update
// multipliers and S_EMIT into the output register; the walk pauses while
// the receiver stalls. output transfers carry index, weight and tlast on the
// final weight.
// the output register holds a weight until it is taken; while it waits the
// weight walk pauses; input is accepted again only once the final weight is loaded.
// config writes (index 0 learning rate, 1 feature count) are always ready.
// reset (synchronous, rst_n low) clears weights, gradients and the row position
// and loads the default register values.
module logistic_regression_gd_trainer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] feature_value
  input  logic        in_tuser,   // [0] label
  input  logic        in_tlast,   // epoch_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [4:0] weight_index, [36:5] weight_value, zero pad
  output logic        out_tlast,  // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_SIG  = 3'd3;
  localparam logic [2:0] S_GRAD = 3'd4;
  localparam logic [2:0] S_UPD1 = 3'd5;
  localparam logic [2:0] S_UPD2 = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  localparam logic REG_LR = 1'b0;
  localparam logic REG_NF = 1'b1;

  localparam int IW = lrg_pkg::IDX_W;
  localparam int CW = lrg_pkg::CNT_W;

  logic [2:0]    state_r, state_nxt;
  logic [15:0]   lr_r;
  logic [5:0]    nf_r;
  logic [IW-1:0] pos_r, j_r, cnt_r;
  logic          label_r, ep_r;
  logic signed [lrg_pkg::FEATURE_BITS-1:0] x_r;
  logic signed [lrg_pkg::SUM_W-1:0]        dot_r;
  logic signed [47:0]                      prod_r;
  logic signed [36:0]                      phi_r;
  logic [35:0]                             plo_r;
  logic signed [lrg_pkg::W_W-1:0]          wsel_r, wnew;
  lrg_pkg::chain_t                         launch_r;
  lrg_pkg::cmd_t                           cmd;
  logic          out_valid_r, out_last_r;
  logic [IW-1:0] out_idx_r;
  logic signed [lrg_pkg::W_W-1:0] out_w_r;

  lrg_pkg::chain_t                  chain [lrg_pkg::MAX_FEATURES+1];
  logic signed [lrg_pkg::W_W-1:0]   w_arr [lrg_pkg::MAX_FEATURES];
  logic signed [lrg_pkg::SUM_W-1:0] g_arr [lrg_pkg::MAX_FEATURES];

  logic [CW-1:0] n_eff;
  logic          row_end, out_load, j_last;
  logic signed [47:0] dot_sum;
  logic signed [lrg_pkg::SUM_W:0] a_abs;
  logic [16:0]   y, p;
  logic signed [lrg_pkg::ERR_W-1:0] err;
  logic signed [57:0] step_full;
  logic signed [42:0] wdiff;
  logic signed [lrg_pkg::SUM_W-1:0] gsel;

  assign chain[0] = launch_r;

  for (genvar i = 0; i < lrg_pkg::MAX_FEATURES; i++) begin : g_cells
    lrg_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (IW'(i)),
      .cmd       (cmd),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .weight    (w_arr[i]),
      .grad      (g_arr[i])
    );
  end

  always_comb begin
    if (nf_r == '0) n_eff = CW'(1);
    else if (CW'(nf_r) > CW'(lrg_pkg::MAX_FEATURES)) n_eff = CW'(lrg_pkg::MAX_FEATURES);
    else n_eff = CW'(nf_r);
  end

  assign row_end  = ({1'b0, pos_r} + CW'(1) >= n_eff) || ep_r;
  assign j_last   = ({1'b0, j_r} + CW'(1) == n_eff);
  assign out_load = (state_r == S_EMIT) && (!out_valid_r || out_tready);
  assign dot_sum  = 48'(dot_r) + 48'(prod_r >>> 12);
  assign gsel     = g_arr[j_r];

  always_comb begin
    a_abs = dot_r[lrg_pkg::SUM_W-1] ? -(lrg_pkg::SUM_W+1)'(dot_r) : (lrg_pkg::SUM_W+1)'(dot_r);
    if (a_abs >= 41'sd327680) y = 17'd65536;
    else if (a_abs >= 41'sd155648) y = 17'(a_abs >>> 5) + 17'd55296;
    else if (a_abs >= 41'sd65536) y = 17'(a_abs >>> 3) + 17'd40960;
    else y = 17'(a_abs >>> 2) + 17'd32768;
    if (dot_r[lrg_pkg::SUM_W-1]) y = 17'd65536 - y;
    p = (y > 17'd65535) ? 17'd65535 : y;
    err = lrg_pkg::ERR_W'(signed'({1'b0, p})) - (label_r ? 18'sd65536 : 18'sd0);
  end

  always_comb begin
    step_full = (58'(phi_r) <<< 20) + 58'(signed'({1'b0, plo_r}));
    wdiff = 43'(wsel_r) - 43'(step_full >>> 16);
    if (wdiff > 43'sd2147483647) wnew = 32'sh7fffffff;
    else if (wdiff < -43'sd2147483648) wnew = 32'sh80000000;
    else wnew = wdiff[lrg_pkg::W_W-1:0];
  end

  always_comb begin
    cmd = '0;
    cmd.row_we  = in_tvalid && in_tready;
    cmd.row_idx = pos_r;
    cmd.row_val = in_tdata;
    cmd.w_we    = (state_r == S_UPD2);
    cmd.w_idx   = j_r;
    cmd.w_val   = wnew;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_ACC;
      S_ACC:  state_nxt = row_end ? S_SIG : S_IDLE;
      S_SIG:  state_nxt = S_GRAD;
      S_GRAD: if (cnt_r == IW'(lrg_pkg::MAX_FEATURES - 1)) state_nxt = ep_r ? S_UPD1 : S_IDLE;
      S_UPD1: state_nxt = S_UPD2;
      S_UPD2: state_nxt = S_EMIT;
      S_EMIT: if (out_load) state_nxt = j_last ? S_IDLE : S_UPD1;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lr_r        <= 16'd655;
      nf_r        <= 6'd26;
      pos_r       <= '0;
      dot_r       <= '0;
      launch_r    <= '0;
      out_valid_r <= 1'b0;
      j_r         <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      launch_r.vld <= (state_r == S_SIG);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LR:  lr_r <= cfg_data;
          REG_NF:  nf_r <= cfg_data[5:0];
          default: ;
        endcase
      end
      if (state_r == S_ACC) begin
        dot_r <= lrg_pkg::sat40(dot_sum);
        if (!row_end) pos_r <= pos_r + IW'(1);
      end
      if (state_r == S_SIG) begin
        launch_r.err <= err;
        launch_r.lim <= pos_r;
        dot_r <= '0;
        pos_r <= '0;
        cnt_r <= '0;
        j_r   <= '0;
      end
      if (state_r == S_GRAD) cnt_r <= cnt_r + IW'(1);
      if (out_load) begin
        out_valid_r <= 1'b1;
        j_r <= j_r + IW'(1);
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      x_r     <= in_tdata;
      label_r <= in_tuser;
      ep_r    <= in_tlast;
    end
    prod_r <= w_arr[pos_r] * x_r;
    phi_r  <= signed'({1'b0, lr_r}) * signed'(gsel[lrg_pkg::SUM_W-1:20]);
    plo_r  <= lr_r * gsel[19:0];
    wsel_r <= w_arr[j_r];
    if (out_load) begin
      out_idx_r  <= j_r;
      out_w_r    <= w_arr[j_r];
      out_last_r <= j_last;
    end
  end

  // the updated weight is latched from the cell on the emit cycle
  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_w_r, out_idx_r};
  assign out_tlast  = out_last_r;

endmodule

// ===== sv/lrg_cell.sv =====
// one cell of the trainer row: holds a weight, its gradient and a row feature
// depends on lrg_pkg
module lrg_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [lrg_pkg::IDX_W-1:0] cell_idx,
  input  lrg_pkg::cmd_t            cmd,
  input  lrg_pkg::chain_t          chain_in,
  output lrg_pkg::chain_t          chain_out,
  output logic signed [lrg_pkg::W_W-1:0]   weight,
  output logic signed [lrg_pkg::SUM_W-1:0] grad
);

  logic signed [lrg_pkg::W_W-1:0]          weight_r;
  logic signed [lrg_pkg::SUM_W-1:0]        grad_r, grad_nxt;
  logic signed [lrg_pkg::FEATURE_BITS-1:0] row_r;
  lrg_pkg::chain_t                         chain_r;
  logic signed [lrg_pkg::ERR_W+lrg_pkg::FEATURE_BITS-1:0] prod;
  logic signed [47:0]                      sum;

  always_comb begin
    prod = chain_in.err * row_r;
    sum  = 48'(grad_r) + 48'(prod >>> 12);
    grad_nxt = grad_r;
    if (cmd.w_we && cmd.w_idx == cell_idx) begin
      grad_nxt = '0;
    end else if (chain_in.vld && cell_idx <= chain_in.lim) begin
      grad_nxt = lrg_pkg::sat40(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= '0;
      grad_r   <= '0;
      chain_r  <= '0;
    end else begin
      grad_r  <= grad_nxt;
      chain_r <= chain_in;
      if (cmd.w_we && cmd.w_idx == cell_idx) begin
        weight_r <= cmd.w_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.row_we && cmd.row_idx == cell_idx) begin
      row_r <= cmd.row_val;
    end
  end

  assign chain_out = chain_r;
  assign weight    = weight_r;
  assign grad      = grad_r;

endmodule

// ===== sv/lrg_checker.sv =====
// port level checks for the trainer
// depends on logistic_regression_gd_trainer_unit ports only
module lrg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken on consecutive cycles");

  a_walk: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && out_tvalid |-> out_tlast)
    else $error("input ready during weight walk");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind logistic_regression_gd_trainer_unit lrg_checker u_lrg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
